/* rtl/pht_pkg.sv */
package pht_pkg;

  localparam int ADDR_BITS     = 48;
  localparam int PAGE_SHIFT    = 12;
  localparam int PAGE_BITS     = ADDR_BITS - PAGE_SHIFT;
  localparam int MAX_SIZE_LOG2 = 10;
  localparam int MIN_SIZE_LOG2 = 4;
  localparam int SLOTS         = 1 << MAX_SIZE_LOG2;
  localparam int IDX_W         = MAX_SIZE_LOG2;
  localparam int LG_W          = 4;
  localparam int MAX_PAGES     = 256;
  localparam int COUNT_W       = 9;
  localparam int BLOCK_ID_BITS = 16;
  localparam int BLK_IN_W      = 16;
  localparam int STATUS_W      = 2;
  localparam int Q_DEPTH       = 2;
  localparam int QA_W          = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

  localparam logic [LG_W-1:0] SIZE_LOG2_RESET = LG_W'(MAX_SIZE_LOG2);

  localparam logic KIND_LOOKUP = 1'b0;
  localparam logic KIND_INSERT = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic                kind;
    logic [ADDR_BITS-1:0] address;
    logic [COUNT_W-1:0]  page_count;
    logic [BLK_IN_W-1:0] block_id;
  } pht_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BLK_IN_W-1:0] found_block;
    logic [COUNT_W-1:0]  pages_done;
  } pht_out_t;

  // classified item as it waits between front and back
  typedef struct packed {
    logic                     kind;
    logic [PAGE_BITS-1:0]     page;
    logic [COUNT_W-1:0]       count;
    logic [BLOCK_ID_BITS-1:0] blk;
  } pht_job_t;

  // back-end status toward the front
  typedef struct packed {
    logic take;
    logic clearing;
  } pht_bstat_t;

endpackage

/* rtl/pht_front.sv */
module pht_front
  import pht_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  pht_in_t    in_item,
  input  pht_bstat_t bstat,
  output logic       q_valid,
  output pht_job_t   q_job
);

  pht_job_t        q_r [Q_DEPTH];
  logic [QA_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QA_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QA_W:0]   cnt_r, cnt_nxt;
  logic            push;
  logic            pop;
  pht_job_t        job_c;

  // classify: page number, clamped page count, block id
  always_comb begin
    job_c.kind  = in_item.kind;
    job_c.page  = in_item.address[ADDR_BITS-1:PAGE_SHIFT];
    job_c.count = (in_item.page_count > COUNT_W'(MAX_PAGES)) ? COUNT_W'(MAX_PAGES)
                                                             : in_item.page_count;
    job_c.blk   = in_item.block_id[BLOCK_ID_BITS-1:0];
  end

  assign busy    = (cnt_r == (QA_W+1)'(Q_DEPTH)) || bstat.clearing;
  assign push    = start && !busy;
  assign pop     = bstat.take;
  assign q_valid = (cnt_r != '0);
  assign q_job   = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QA_W'(Q_DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QA_W'(Q_DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= job_c;
    end
  end

endmodule

/* rtl/pht_back.sv */
module pht_back
  import pht_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] mask,
  input  logic             q_valid,
  input  pht_job_t         q_job,
  output pht_bstat_t       bstat,
  output logic             out_valid,
  output pht_out_t         out_item
);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_READ  = 4'b0100,
    S_CHECK = 4'b1000
  } state_t;

  typedef struct packed {
    logic                     valid;
    logic [PAGE_BITS-1:0]     page;
    logic [BLOCK_ID_BITS-1:0] blk;
  } slot_t;

  slot_t mem [SLOTS];
  slot_t rdata_r;

  state_t             state_r, state_nxt;
  pht_job_t           job_r, job_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [IDX_W-1:0]   k_r, k_nxt;
  logic [COUNT_W-1:0] done_r, done_nxt;
  logic [COUNT_W-1:0] done_inc;
  logic [IDX_W-1:0]   clr_idx_r, clr_idx_nxt;
  logic               out_valid_r, out_valid_nxt;
  pht_out_t           out_r, out_nxt;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  slot_t              mem_wdata;
  logic               take;
  logic               hit;
  logic [PAGE_BITS-1:0] page_inc;

  assign hit      = rdata_r.valid && (rdata_r.page == job_r.page);
  assign done_inc = done_r + 1'b1;
  assign page_inc = job_r.page + 1'b1;

  always_comb begin
    state_nxt     = state_r;
    job_nxt       = job_r;
    idx_nxt       = idx_r;
    k_nxt         = k_r;
    done_nxt      = done_r;
    clr_idx_nxt   = clr_idx_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    mem_we        = 1'b0;
    mem_waddr     = idx_r;
    mem_wdata     = '{valid: 1'b1, page: job_r.page, blk: job_r.blk};
    take          = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        mem_we      = 1'b1;
        mem_waddr   = clr_idx_r;
        mem_wdata   = '0;
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == IDX_W'(SLOTS-1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          take     = 1'b1;
          job_nxt  = q_job;
          idx_nxt  = q_job.page[IDX_W-1:0] & mask;
          k_nxt    = '0;
          done_nxt = '0;
          if (q_job.kind == KIND_INSERT && q_job.count == '0) begin
            out_valid_nxt = 1'b1;
            out_nxt       = '{status: ST_OK, found_block: '0, pages_done: '0};
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (!rdata_r.valid || hit) begin
          if (job_r.kind == KIND_LOOKUP) begin
            out_valid_nxt = 1'b1;
            out_nxt.status      = hit ? ST_OK : ST_NOT_FOUND;
            out_nxt.found_block = hit ? BLK_IN_W'(rdata_r.blk) : '0;
            out_nxt.pages_done  = '0;
            state_nxt = S_IDLE;
          end else begin
            mem_we   = 1'b1;
            done_nxt = done_inc;
            if (done_inc == job_r.count) begin
              out_valid_nxt = 1'b1;
              out_nxt = '{status: ST_OK, found_block: '0, pages_done: done_inc};
              state_nxt = S_IDLE;
            end else begin
              job_nxt.page = page_inc;
              idx_nxt      = page_inc[IDX_W-1:0] & mask;
              k_nxt        = '0;
              state_nxt    = S_READ;
            end
          end
        end else if (k_r == mask) begin
          // every slot visited, no match and no empty slot
          out_valid_nxt = 1'b1;
          if (job_r.kind == KIND_LOOKUP) begin
            out_nxt = '{status: ST_NOT_FOUND, found_block: '0, pages_done: '0};
          end else begin
            out_nxt = '{status: ST_FULL, found_block: '0, pages_done: done_r};
          end
          state_nxt = S_IDLE;
        end else begin
          // triangular step: T(k+1) = T(k) + k + 1
          k_nxt     = k_r + 1'b1;
          idx_nxt   = (idx_r + k_nxt) & mask;
          state_nxt = S_READ;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r  <= job_nxt;
    idx_r  <= idx_nxt;
    k_r    <= k_nxt;
    done_r <= done_nxt;
    out_r  <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[idx_r];
  end

  assign bstat.take     = take;
  assign bstat.clearing = (state_r == S_CLEAR);
  assign out_valid      = out_valid_r;
  assign out_item       = out_r;

  a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHECK) |-> (k_r <= mask))
    else $error("probe step ran past table size");

  a_done_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.pages_done <= job_r.count))
    else $error("more pages reported than requested");

  a_lookup_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && job_r.kind == KIND_LOOKUP) |-> (out_r.pages_done == '0))
    else $error("lookup reported stored pages");

  a_clear_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(state_r == S_CLEAR) |-> ($past(clr_idx_r) == IDX_W'(SLOTS-1)))
    else $error("clearing pass ended early");

endmodule

/* rtl/page_hash_table_probe.sv */
// Page hash table probe: open-addressing table from 36-bit page numbers
// (address >> 12) to 16-bit block ids, probed at (page + k(k+1)/2) mod 2^n with
// n = cfg_wdata clamped to 4..10. An item is taken when start is high and busy
// is low; a lookup or an insert of page_count pages (clamped to 256) gives
// exactly one result, shown for one cycle with out_valid high. The receiver
// cannot stall: results must be taken as they come. After reset the block runs
// a clearing pass over the slot memory with busy high. Each item is first taken
// from the two-entry input queue; each probe step is then a memory read, then a
// compare and optional write, through the one slot memory. Up to two items wait
// in the queue while the probe engine works. Write cfg only when idle; entries
// are not rehashed when the size changes.
module page_hash_table_probe
  import pht_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  pht_in_t         in_item,
  output logic            out_valid,
  output pht_out_t        out_item,
  input  logic            cfg_we,
  input  logic [LG_W-1:0] cfg_wdata
);

  logic [LG_W-1:0]  size_log2_r;
  logic [LG_W-1:0]  size_lg;
  logic [IDX_W-1:0] mask;
  pht_bstat_t       bstat;
  logic             q_valid;
  pht_job_t         q_job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_log2_r <= SIZE_LOG2_RESET;
    end else if (cfg_we) begin
      size_log2_r <= cfg_wdata;
    end
  end

  // size in use, then slot mask
  always_comb begin
    if (size_log2_r < LG_W'(MIN_SIZE_LOG2)) begin
      size_lg = LG_W'(MIN_SIZE_LOG2);
    end else if (size_log2_r > LG_W'(MAX_SIZE_LOG2)) begin
      size_lg = LG_W'(MAX_SIZE_LOG2);
    end else begin
      size_lg = size_log2_r;
    end
    mask = ~({IDX_W{1'b1}} << size_lg);
  end

  pht_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_item (in_item),
    .bstat   (bstat),
    .q_valid (q_valid),
    .q_job   (q_job)
  );

  pht_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mask      (mask),
    .q_valid   (q_valid),
    .q_job     (q_job),
    .bstat     (bstat),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
